// ===== rtl/core/dawl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dawl_pkg;

    // request codes, in the encoding of the opcode port
    typedef enum logic [1:0] {
        OP_ALLOW = 2'd0,
        OP_DENY  = 2'd1,
        OP_CHECK = 2'd2,
        OP_BAD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DENIED = 2'd1,
        ST_FULL   = 2'd2,
        ST_BAD    = 2'd3
    } t_status;

    localparam logic [1:0] KIND_BLOCK = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_ALL   = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [3:0] ACC_FULL   = 4'hF;

    typedef struct packed {
        t_op         op;
        logic [1:0]  dev_kind;
        logic [11:0] major_num;
        logic        major_any;
        logic [19:0] minor_num;
        logic        minor_any;
        logic [3:0]  access_bits;
    } t_req;

    // request plus what the walk has gathered so far
    typedef struct packed {
        t_req req;
        logic merged;
        logic hit;
        logic free_found;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/core/dawl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dawl_cell #(
    parameter int IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_home,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic             i_tok_vld,
    input  wire dawl_pkg::t_tok   i_tok,
    input  wire logic [IDX_W-1:0] i_free_idx,
    input  wire logic             i_wr,
    input  wire dawl_pkg::t_req   i_wr_req,
    output logic                  o_tok_vld,
    output dawl_pkg::t_tok        o_tok,
    output logic [IDX_W-1:0]      o_free_idx
);

    logic        r_valid;
    logic [1:0]  r_type;
    logic [11:0] r_major;
    logic        r_major_wild;
    logic [19:0] r_minor;
    logic        r_minor_wild;
    logic [3:0]  r_access;

    logic        r_tok_vld;
    dawl_pkg::t_tok r_tok;
    logic [IDX_W-1:0] r_free_idx;

    dawl_pkg::t_tok   n_tok;
    logic [IDX_W-1:0] n_free_idx;
    logic [3:0]       n_access;
    logic             n_valid;

    logic exact_hit;
    logic deny_hit;
    logic check_hit;
    logic maj_eq;
    logic min_eq;

    assign maj_eq = (r_major == i_tok.req.major_num);
    assign min_eq = (r_minor == i_tok.req.minor_num);

    always_comb begin
        exact_hit = r_valid && (r_type == i_tok.req.dev_kind)
                 && (r_major_wild == i_tok.req.major_any)
                 && (r_minor_wild == i_tok.req.minor_any)
                 && (i_tok.req.major_any || maj_eq)
                 && (i_tok.req.minor_any || min_eq);
        deny_hit = r_valid && ((r_type == dawl_pkg::KIND_ALL)
                 || ((r_type == i_tok.req.dev_kind)
                     && (r_major_wild || (!i_tok.req.major_any && maj_eq))
                     && (r_minor_wild || (!i_tok.req.minor_any && min_eq))));
        check_hit = r_valid && ((r_type == dawl_pkg::KIND_ALL)
                 || ((r_type == i_tok.req.dev_kind)
                     && (r_major_wild || maj_eq)
                     && (r_minor_wild || min_eq)))
                 && ((i_tok.req.access_bits & ~r_access) == 4'd0);
    end

    always_comb begin
        n_tok      = i_tok;
        n_free_idx = i_free_idx;
        n_access   = r_access;
        n_valid    = r_valid;
        if (!r_valid && !i_tok.free_found) begin
            n_tok.free_found = 1'b1;
            n_free_idx       = i_idx;
        end
        case (i_tok.req.op)
            dawl_pkg::OP_ALLOW: begin
                if (exact_hit) begin
                    n_tok.merged = 1'b1;
                    n_access     = (r_access | i_tok.req.access_bits) & dawl_pkg::ACC_FULL;
                end
            end
            dawl_pkg::OP_DENY: begin
                if (deny_hit) begin
                    n_access = r_access & ~i_tok.req.access_bits & dawl_pkg::ACC_FULL;
                    n_valid  = (n_access != 4'd0);
                end
            end
            dawl_pkg::OP_CHECK: begin
                if (check_hit) begin
                    n_tok.hit = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // entry state; the home cell wakes up as the catch-all entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= i_home;
            r_type       <= dawl_pkg::KIND_ALL;
            r_major_wild <= 1'b1;
            r_minor_wild <= 1'b1;
            r_access     <= dawl_pkg::ACC_FULL;
        end else if (i_wr) begin
            r_valid      <= 1'b1;
            r_type       <= i_wr_req.dev_kind;
            r_major_wild <= i_wr_req.major_any;
            r_minor_wild <= i_wr_req.minor_any;
            r_access     <= i_wr_req.access_bits & dawl_pkg::ACC_FULL;
        end else if (i_tok_vld) begin
            r_valid  <= n_valid;
            r_access <= n_access;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_major <= i_wr_req.major_any ? 12'd0 : i_wr_req.major_num;
            r_minor <= i_wr_req.minor_any ? 20'd0 : i_wr_req.minor_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_vld) begin
            r_tok      <= n_tok;
            r_free_idx <= n_free_idx;
        end
    end

    assign o_tok_vld  = r_tok_vld;
    assign o_tok      = r_tok;
    assign o_free_idx = r_free_idx;

endmodule

`default_nettype wire

// ===== rtl/core/device_access_whitelist.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake                 | payload
// --------+---------------------------+------------------------------------------
// input   | i_in_valid / o_in_stall   | i_opcode i_dev_kind i_major_num
//         |                           | i_major_any i_minor_num i_minor_any
//         |                           | i_access_bits
// output  | o_out_valid / i_out_stall | o_status
//
// one word at a time: a request walks the row of ENTRIES entry cells, one cell
// per cycle, and the result is registered after the walk leaves the last cell
// the input stalls from acceptance until the result word is taken, so a new word
// is taken only once the last result word has left
// a new table entry is written in the cycle the walk leaves the last cell
// after reset only entry zero is in use (any device, all access bits)

module device_access_whitelist #(
    parameter int ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [1:0]  i_dev_kind,
    input  wire logic [11:0] i_major_num,
    input  wire logic        i_major_any,
    input  wire logic [19:0] i_minor_num,
    input  wire logic        i_minor_any,
    input  wire logic [3:0]  i_access_bits,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic r_busy;
    logic r_out_vld;
    dawl_pkg::t_status r_status;
    dawl_pkg::t_status n_status;

    logic             in_acc;
    logic             out_acc;
    dawl_pkg::t_tok   n_head;
    logic [ENTRIES:0] tok_vld;
    dawl_pkg::t_tok   tok [ENTRIES+1];
    logic [IDX_W-1:0] fidx [ENTRIES+1];
    logic             do_append;

    logic           r_head_vld;
    dawl_pkg::t_tok r_head;

    assign in_acc  = i_in_valid && !r_busy;
    assign out_acc = r_out_vld && !i_out_stall;

    // request decode, bad codes marked, all-type rule widened to the catch-all form
    always_comb begin
        n_head.req.op          = dawl_pkg::t_op'(i_opcode);
        n_head.req.dev_kind    = i_dev_kind;
        n_head.req.major_num   = i_major_num;
        n_head.req.major_any   = i_major_any;
        n_head.req.minor_num   = i_minor_num;
        n_head.req.minor_any   = i_minor_any;
        n_head.req.access_bits = i_access_bits;
        n_head.merged          = 1'b0;
        n_head.free_found      = 1'b0;
        // a check of device zero is let through unless the request is marked bad
        n_head.hit             = (i_major_num == 12'd0) && (i_minor_num == 20'd0);
        if (i_dev_kind == dawl_pkg::KIND_BAD
                || (n_head.req.op == dawl_pkg::OP_CHECK
                    && i_dev_kind == dawl_pkg::KIND_ALL)) begin
            n_head.req.op = dawl_pkg::OP_BAD;
        end else if (i_dev_kind == dawl_pkg::KIND_ALL) begin
            n_head.req.major_any   = 1'b1;
            n_head.req.minor_any   = 1'b1;
            n_head.req.major_num   = 12'd0;
            n_head.req.minor_num   = 20'd0;
            n_head.req.access_bits = dawl_pkg::ACC_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
        end else begin
            r_head_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_head <= n_head;
        end
    end

    assign tok_vld[0] = r_head_vld;
    assign tok[0]     = r_head;
    assign fidx[0]    = '0;

    assign do_append = tok_vld[ENTRIES] && (tok[ENTRIES].req.op == dawl_pkg::OP_ALLOW)
                    && !tok[ENTRIES].merged && tok[ENTRIES].free_found;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        dawl_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_home     (g == 0),
            .i_idx      (IDX_W'(g)),
            .i_tok_vld  (tok_vld[g]),
            .i_tok      (tok[g]),
            .i_free_idx (fidx[g]),
            .i_wr       (do_append && (fidx[ENTRIES] == IDX_W'(g))),
            .i_wr_req   (tok[ENTRIES].req),
            .o_tok_vld  (tok_vld[g+1]),
            .o_tok      (tok[g+1]),
            .o_free_idx (fidx[g+1])
        );
    end

    always_comb begin
        unique case (tok[ENTRIES].req.op)
            dawl_pkg::OP_ALLOW: begin
                n_status = (tok[ENTRIES].merged || tok[ENTRIES].free_found)
                         ? dawl_pkg::ST_OK : dawl_pkg::ST_FULL;
            end
            dawl_pkg::OP_DENY:  n_status = dawl_pkg::ST_OK;
            dawl_pkg::OP_CHECK: begin
                n_status = tok[ENTRIES].hit ? dawl_pkg::ST_OK : dawl_pkg::ST_DENIED;
            end
            default:            n_status = dawl_pkg::ST_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (out_acc) begin
                r_busy <= 1'b0;
            end
            if (tok_vld[ENTRIES]) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_vld[ENTRIES]) begin
            r_status <= n_status;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dawl_pkg::*;

    localparam int ENTRIES        = 16;
    localparam int WALK_CYCLES    = ENTRIES + 2;
    localparam int EPISODE_LEN    = 50;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        t_req    req;
        t_status st;
    } t_due;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    t_req       cur_req   = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_status;

    t_req pending[$];
    t_due status_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures      = 0;
    int quiet_cycles  = 0;

    // predicted whitelist
    bit        wl_used       [ENTRIES];
    bit [1:0]  wl_kind       [ENTRIES];
    bit [11:0] wl_major      [ENTRIES];
    bit        wl_major_wild [ENTRIES];
    bit [19:0] wl_minor      [ENTRIES];
    bit        wl_minor_wild [ENTRIES];
    bit [3:0]  wl_acc        [ENTRIES];

    bit [11:0] major_pool [3];
    bit [19:0] minor_pool [3];

    wire in_fire  = in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !out_stall;

    device_access_whitelist #(.ENTRIES(ENTRIES)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (cur_req.op),
        .i_dev_kind    (cur_req.dev_kind),
        .i_major_num   (cur_req.major_num),
        .i_major_any   (cur_req.major_any),
        .i_minor_num   (cur_req.minor_num),
        .i_minor_any   (cur_req.minor_any),
        .i_access_bits (cur_req.access_bits),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic whitelist_reset();
        for (int i = 0; i < ENTRIES; i++) begin
            wl_used[i]       = 1'b0;
            wl_kind[i]       = KIND_BLOCK;
            wl_major[i]      = '0;
            wl_major_wild[i] = 1'b0;
            wl_minor[i]      = '0;
            wl_minor_wild[i] = 1'b0;
            wl_acc[i]        = '0;
        end
        wl_used[0]       = 1'b1;
        wl_kind[0]       = KIND_ALL;
        wl_major_wild[0] = 1'b1;
        wl_minor_wild[0] = 1'b1;
        wl_acc[0]        = ACC_FULL;
    endtask

    // applies one request to the predicted table and returns its status
    function automatic t_status whitelist_status(t_req r);
        bit [1:0]  kind;
        bit [11:0] maj;
        bit        majw;
        bit [19:0] mnr;
        bit        mnrw;
        bit [3:0]  acc;
        int        free_slot;
        bit        merged;
        bit        hit;
        kind = r.dev_kind;
        maj  = r.major_num;
        majw = r.major_any;
        mnr  = r.minor_num;
        mnrw = r.minor_any;
        acc  = r.access_bits;
        if (r.op == OP_BAD || kind == KIND_BAD)
            return ST_BAD;
        if (r.op == OP_CHECK) begin
            if (kind == KIND_ALL)
                return ST_BAD;
            if (maj == 0 && mnr == 0)
                return ST_OK;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!wl_used[i])
                    continue;
                hit = wl_kind[i] == KIND_ALL ||
                      (wl_kind[i] == kind &&
                       (wl_major_wild[i] || wl_major[i] == maj) &&
                       (wl_minor_wild[i] || wl_minor[i] == mnr));
                if (hit && (acc & ~wl_acc[i]) == 0)
                    return ST_OK;
            end
            return ST_DENIED;
        end
        // an all-type rule covers everything, whatever the other fields say
        if (kind == KIND_ALL) begin
            majw = 1'b1;
            mnrw = 1'b1;
            maj  = '0;
            mnr  = '0;
            acc  = ACC_FULL;
        end
        if (r.op == OP_ALLOW) begin
            free_slot = -1;
            merged    = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!wl_used[i]) begin
                    if (free_slot < 0)
                        free_slot = i;
                end else if (wl_kind[i] == kind && wl_major_wild[i] == majw &&
                             wl_minor_wild[i] == mnrw && (majw || wl_major[i] == maj) &&
                             (mnrw || wl_minor[i] == mnr)) begin
                    wl_acc[i] = wl_acc[i] | acc;
                    merged    = 1'b1;
                end
            end
            if (merged)
                return ST_OK;
            if (free_slot < 0)
                return ST_FULL;
            wl_used[free_slot]       = 1'b1;
            wl_kind[free_slot]       = kind;
            wl_major[free_slot]      = majw ? 12'd0 : maj;
            wl_major_wild[free_slot] = majw;
            wl_minor[free_slot]      = mnrw ? 20'd0 : mnr;
            wl_minor_wild[free_slot] = mnrw;
            wl_acc[free_slot]        = acc;
            return ST_OK;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!wl_used[i])
                continue;
            hit = wl_kind[i] == KIND_ALL ||
                  (wl_kind[i] == kind &&
                   (wl_major_wild[i] || (!majw && wl_major[i] == maj)) &&
                   (wl_minor_wild[i] || (!mnrw && wl_minor[i] == mnr)));
            if (hit) begin
                wl_acc[i] = wl_acc[i] & ~acc;
                if (wl_acc[i] == 0)
                    wl_used[i] = 1'b0;
            end
        end
        return ST_OK;
    endfunction

    task automatic push_req(t_op op, bit [1:0] kind, bit [11:0] maj, bit majw,
                            bit [19:0] mnr, bit mnrw, bit [3:0] acc);
        t_req r;
        r.op          = op;
        r.dev_kind    = kind;
        r.major_num   = maj;
        r.major_any   = majw;
        r.minor_num   = mnr;
        r.minor_any   = mnrw;
        r.access_bits = acc;
        pending.push_back(r);
    endtask

    function automatic bit [11:0] pick_major();
        case ($urandom_range(9))
            0:             return 12'd0;
            1:             return 12'hFFF;
            2, 3, 4, 5, 6: return major_pool[$urandom_range(2)];
            default:       return 12'($urandom);
        endcase
    endfunction

    function automatic bit [19:0] pick_minor();
        case ($urandom_range(9))
            0:             return 20'd0;
            1:             return 20'hFFFFF;
            2, 3, 4, 5, 6: return minor_pool[$urandom_range(2)];
            default:       return 20'($urandom);
        endcase
    endfunction

    // numbers come mostly from small pools so that rules and checks collide
    function automatic t_req random_req(int allow_pct, int deny_pct);
        t_req r;
        int   roll;
        roll = $urandom_range(99);
        if (roll < 3)
            r.op = OP_BAD;
        else if (roll < 3 + allow_pct)
            r.op = OP_ALLOW;
        else if (roll < 3 + allow_pct + deny_pct)
            r.op = OP_DENY;
        else
            r.op = OP_CHECK;
        roll = $urandom_range(99);
        if (roll < 3)
            r.dev_kind = KIND_BAD;
        else if (roll < 10)
            r.dev_kind = KIND_ALL;
        else if (roll < 55)
            r.dev_kind = KIND_BLOCK;
        else
            r.dev_kind = KIND_CHAR;
        r.major_num   = pick_major();
        r.major_any   = $urandom_range(99) < 30;
        r.minor_num   = pick_minor();
        r.minor_any   = $urandom_range(99) < 30;
        r.access_bits = 4'($urandom_range(15));
        return r;
    endfunction

    task automatic load_episode(int allow_pct, int deny_pct);
        for (int k = 0; k < 3; k++) begin
            major_pool[k] = (k == 2) ? 12'($urandom) : 12'($urandom_range(1, 6));
            minor_pool[k] = (k == 2) ? 20'($urandom) : 20'($urandom_range(1, 6));
        end
        repeat (EPISODE_LEN) pending.push_back(random_req(allow_pct, deny_pct));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending.size() != 0 || in_valid || status_due.size() != 0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_fire)
                status_due.push_back('{req: cur_req, st: whitelist_status(cur_req)});
            if (!in_valid || !o_in_stall) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    cur_req  <= pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_due due;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_fire) begin
                if (status_due.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result word: status %0d", o_status);
                end else begin
                    due = status_due.pop_front();
                    if (o_status !== due.st) begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: op %0d kind %0d maj %0d/%0b min %0d/%0b acc %h: expected %0d, got %0d",
                                     due.req.op, due.req.dev_kind, due.req.major_num,
                                     due.req.major_any, due.req.minor_num, due.req.minor_any,
                                     due.req.access_bits, due.st, o_status);
                    end
                end
            end
            out_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int mix_allow [4];
        int mix_deny  [4];
        int mix;
        mix_allow = '{85, 20, 15, 40};
        mix_deny  = '{5, 60, 10, 30};
        whitelist_reset();
        send_idle_pct = 21;
        recv_idle_pct = 52;

        // device zero, bad codes, the all-type entry and its removal
        push_req(OP_CHECK, KIND_BLOCK, 12'd0, 1'b0, 20'd0, 1'b0, 4'hF);
        push_req(OP_CHECK, KIND_CHAR, 12'hFFF, 1'b1, 20'hFFFFF, 1'b1, 4'hF);
        push_req(OP_CHECK, KIND_ALL, 12'd5, 1'b0, 20'd5, 1'b0, 4'h1);
        push_req(OP_BAD, KIND_BLOCK, 12'd1, 1'b0, 20'd1, 1'b0, 4'h1);
        push_req(OP_ALLOW, KIND_BAD, 12'd1, 1'b0, 20'd1, 1'b0, 4'h1);
        push_req(OP_DENY, KIND_BAD, 12'd1, 1'b0, 20'd1, 1'b0, 4'hF);
        push_req(OP_DENY, KIND_ALL, 12'd123, 1'b0, 20'd456, 1'b0, 4'h0);
        push_req(OP_CHECK, KIND_BLOCK, 12'd1, 1'b0, 20'd2, 1'b0, 4'h0);
        push_req(OP_CHECK, KIND_CHAR, 12'd0, 1'b0, 20'd0, 1'b0, 4'hF);
        // exact, wildcard and empty entries, merging
        push_req(OP_ALLOW, KIND_BLOCK, 12'hFFF, 1'b0, 20'hFFFFF, 1'b0, 4'hA);
        push_req(OP_ALLOW, KIND_CHAR, 12'hFFF, 1'b1, 20'd5, 1'b0, 4'h3);
        push_req(OP_ALLOW, KIND_BLOCK, 12'd8, 1'b0, 20'd99, 1'b1, 4'h0);
        push_req(OP_CHECK, KIND_BLOCK, 12'hFFF, 1'b0, 20'hFFFFF, 1'b0, 4'hA);
        push_req(OP_CHECK, KIND_BLOCK, 12'hFFF, 1'b0, 20'hFFFFF, 1'b0, 4'hB);
        push_req(OP_ALLOW, KIND_BLOCK, 12'hFFF, 1'b0, 20'hFFFFF, 1'b0, 4'h5);
        push_req(OP_CHECK, KIND_BLOCK, 12'hFFF, 1'b0, 20'hFFFFF, 1'b0, 4'hF);
        // a wildcard deny does not reach an exact entry
        push_req(OP_DENY, KIND_BLOCK, 12'hFFF, 1'b0, 20'd0, 1'b1, 4'h1);
        push_req(OP_CHECK, KIND_CHAR, 12'd77, 1'b0, 20'd5, 1'b1, 4'h2);
        push_req(OP_CHECK, KIND_BLOCK, 12'd8, 1'b0, 20'd12345, 1'b0, 4'h0);
        push_req(OP_DENY, KIND_BLOCK, 12'd8, 1'b0, 20'd3, 1'b0, 4'h0);
        push_req(OP_CHECK, KIND_BLOCK, 12'd8, 1'b0, 20'd12345, 1'b0, 4'h0);
        push_req(OP_ALLOW, KIND_ALL, 12'd1, 1'b0, 20'd1, 1'b0, 4'h0);
        push_req(OP_DENY, KIND_CHAR, 12'd0, 1'b1, 20'd0, 1'b1, 4'h3);
        push_req(OP_CHECK, KIND_CHAR, 12'd9, 1'b0, 20'd9, 1'b0, 4'h4);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (phase == 2 ? 10 : 9) begin
                mix = $urandom_range(3);
                load_episode(mix_allow[mix], mix_deny[mix]);
            end
            wait_drained();
        end

        repeat (WALK_CYCLES + 20) @(negedge i_clk);
        failures += status_due.size();
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
